// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// ===== rtl/nzcv_pkg.sv =====
// Shared types, constants and condition evaluation for the NZCV flag block.
package nzcv_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned WIDTH_W = 7;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_ADC   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_SBC   = 3'd3,
    CMD_LOGIC = 3'd4,
    CMD_CONST = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_t;

  typedef struct packed {
    logic [3:0] flags;
    logic       met;
  } result_t;

  // Evaluate one condition code on an NZCV nibble.
  function automatic logic cond_holds(cond_t code, logic [3:0] f);
    logic n;
    logic z;
    logic c;
    logic v;
    logic hit;
    n = f[FLAG_N];
    z = f[FLAG_Z];
    c = f[FLAG_C];
    v = f[FLAG_V];
    unique case (code)
      COND_EQ: hit = z;
      COND_NE: hit = !z;
      COND_CS: hit = c;
      COND_CC: hit = !c;
      COND_MI: hit = n;
      COND_PL: hit = !n;
      COND_VS: hit = v;
      COND_VC: hit = !v;
      COND_HI: hit = c && !z;
      COND_LS: hit = !c || z;
      COND_GE: hit = (n == v);
      COND_LT: hit = (n != v);
      COND_GT: hit = !z && (n == v);
      COND_LE: hit = z || (n != v);
      COND_AL: hit = 1'b1;
      COND_NV: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/nzcv_alu.sv =====
// Combinational flag generation and condition test for one operation.
module nzcv_alu (
  input  logic [2:0]                     command,
  input  logic [nzcv_pkg::WIDTH_W-1:0]   width,
  input  logic [nzcv_pkg::DATA_W-1:0]    operand_a,
  input  logic [nzcv_pkg::DATA_W-1:0]    operand_b,
  input  logic                           carry_in,
  input  logic [3:0]                     condition,
  output nzcv_pkg::result_t              result
);

  nzcv_pkg::cmd_t                   cmd;
  logic [nzcv_pkg::WIDTH_W-1:0]     w_eff;
  logic [$clog2(nzcv_pkg::DATA_W)-1:0] sh;
  logic [nzcv_pkg::DATA_W-1:0]      mask;
  logic [nzcv_pkg::DATA_W-1:0]      a_m;
  logic [nzcv_pkg::DATA_W-1:0]      b_m;
  logic [nzcv_pkg::DATA_W-1:0]      b_op;
  logic                             cin_op;
  logic [nzcv_pkg::DATA_W:0]        sum;
  logic [nzcv_pkg::DATA_W-1:0]      r;
  logic                             sa;
  logic                             sb;
  logic                             sr;
  logic                             c_arith;
  logic                             v_arith;
  logic [3:0]                       f;

  assign cmd = nzcv_pkg::cmd_t'(command);

  // Clamp width into 1..64.
  always_comb begin
    priority if (width == '0) begin
      w_eff = nzcv_pkg::WIDTH_W'(1);
    end else if (width > nzcv_pkg::WIDTH_W'(nzcv_pkg::DATA_W)) begin
      w_eff = nzcv_pkg::WIDTH_W'(nzcv_pkg::DATA_W);
    end else begin
      w_eff = width;
    end
  end

  assign sh = $clog2(nzcv_pkg::DATA_W)'(w_eff - nzcv_pkg::WIDTH_W'(1));

  always_comb begin
    for (int i = 0; i < nzcv_pkg::DATA_W; i++) begin
      mask[i] = (nzcv_pkg::WIDTH_W'(i) < w_eff);
    end
  end

  assign a_m = operand_a & mask;
  assign b_m = operand_b & mask;

  // Subtract runs as a + ~b + cin, so C reads as no borrow.
  always_comb begin
    unique case (cmd)
      nzcv_pkg::CMD_ADD: begin
        b_op   = b_m;
        cin_op = 1'b0;
      end
      nzcv_pkg::CMD_ADC: begin
        b_op   = b_m;
        cin_op = carry_in;
      end
      nzcv_pkg::CMD_SUB: begin
        b_op   = ~b_m & mask;
        cin_op = 1'b1;
      end
      nzcv_pkg::CMD_SBC: begin
        b_op   = ~b_m & mask;
        cin_op = carry_in;
      end
      default: begin
        b_op   = b_m;
        cin_op = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, a_m} + {1'b0, b_op} + (nzcv_pkg::DATA_W+1)'(cin_op);
  assign r   = sum[nzcv_pkg::DATA_W-1:0] & mask;
  assign c_arith = sum[w_eff];
  assign sa = a_m[sh];
  assign sb = b_op[sh];
  assign sr = r[sh];
  assign v_arith = (sa == sb) && (sr != sa);

  always_comb begin
    unique case (cmd)
      nzcv_pkg::CMD_ADD, nzcv_pkg::CMD_ADC, nzcv_pkg::CMD_SUB, nzcv_pkg::CMD_SBC: begin
        f = {sr, (r == '0), c_arith, v_arith};
      end
      nzcv_pkg::CMD_LOGIC: begin
        f = {a_m[sh], (a_m == '0), 2'b00};
      end
      nzcv_pkg::CMD_CONST: begin
        f = operand_a[3:0] & nzcv_pkg::NIBBLE_MASK;
      end
      default: begin
        f = 4'b0000;
      end
    endcase
  end

  assign result.flags = f;
  assign result.met   = nzcv_pkg::cond_holds(nzcv_pkg::cond_t'(condition), f);

endmodule

// ===== rtl/nzcv_flags_and_condition_check.sv =====
// Top level: NZCV flag generator with condition test, two register stages.
//
// Input channel (in_valid / in_ready) carries one beat per operation:
// command, width, operand_a, operand_b, carry_in and condition.
// Output channel (out_valid / out_ready) carries one beat per input beat:
// the NZCV nibble in flags and the result of the condition test in
// condition_met, in the same order as the inputs arrived.
//
// An accepted beat lands in the input register; the flag adder (one 65-bit
// add plus masking and zero detect) sits between the input register and
// the result register, which drives out_valid, flags and condition_met.
// Throughput: one beat per cycle, sustained, while out_ready stays high.
//
// When the receiver stalls, the result register holds its beat and the input
// register fills behind it; in_ready then drops until out_ready returns.
// Nothing is lost or repeated. Reset clears both valid bits; payload
// registers are not reset.
module nzcv_flags_and_condition_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     command,
  input  logic [nzcv_pkg::WIDTH_W-1:0]   width,
  input  logic [nzcv_pkg::DATA_W-1:0]    operand_a,
  input  logic [nzcv_pkg::DATA_W-1:0]    operand_b,
  input  logic                           carry_in,
  input  logic [3:0]                     condition,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     flags,
  output logic                           condition_met
);

  // Input register stage.
  logic                           s1_valid;
  logic [2:0]                     s1_command;
  logic [nzcv_pkg::WIDTH_W-1:0]   s1_width;
  logic [nzcv_pkg::DATA_W-1:0]    s1_operand_a;
  logic [nzcv_pkg::DATA_W-1:0]    s1_operand_b;
  logic                           s1_carry_in;
  logic [3:0]                     s1_condition;

  logic              in_fire;
  logic              s2_load;
  nzcv_pkg::result_t alu_result;

  // Advance stage 1 into the result register when that register is free
  // or being drained this cycle.
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the payload on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_command   <= command;
      s1_width     <= width;
      s1_operand_a <= operand_a;
      s1_operand_b <= operand_b;
      s1_carry_in  <= carry_in;
      s1_condition <= condition;
    end
  end

  nzcv_alu u_alu (
    .command   (s1_command),
    .width     (s1_width),
    .operand_a (s1_operand_a),
    .operand_b (s1_operand_b),
    .carry_in  (s1_carry_in),
    .condition (s1_condition),
    .result    (alu_result)
  );

  // Result register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      flags         <= alu_result.flags;
      condition_met <= alu_result.met;
    end
  end

endmodule

// ===== rtl/nzcv_checker.sv =====
// Port-level checker for the NZCV flag block, bound to the top level.
`include "assert_macros.svh"

module nzcv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] flags,
  input logic       condition_met
);

  // Reset empties the result register.
  `ASSERT_NXT_ALL(a_reset_clears, clk, rst, !out_valid)

  // A stalled result holds its payload.
  `ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(flags) && $stable(condition_met))

  // Every accepted beat is followed by out_valid high once it has passed the input register.
  `ASSERT_NXT(a_latency, clk, rst, in_valid && in_ready, ##1 out_valid)

  // A new output burst always stems from an input beat that went straight through the input register.
  `ASSERT_IMP(a_no_phantom, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind nzcv_flags_and_condition_check nzcv_checker u_nzcv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .flags         (flags),
  .condition_met (condition_met)
);
